>>> rtl/core/mnps_pkg.sv
// mean nearest pivot select: shared constants, value type, back-end state and status
// no dependencies
`timescale 1ns / 1ps

package mnps_pkg;

   localparam int unsigned MAX_ITEMS_DEF = 512;
   localparam int unsigned VALUE_W       = 32;

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_SCAN,
      BK_RESP
   } back_state_type;

   // back-end status seen by the loader and the top level
   typedef struct packed {
      logic mem_busy;
   } back_status_type;

endpackage

>>> rtl/core/mnps_if.sv
// request and response channel interfaces for the pivot selector
// depends on mnps_pkg
`timescale 1ns / 1ps

interface mnps_req_if;
   import mnps_pkg::*;
   logic      valid;
   logic      ready;
   value_type value;
   logic      last;
   logic      side_a;
   modport source (output valid, value, last, side_a, input ready);
   modport sink (input valid, value, last, side_a, output ready);
endinterface

interface mnps_rsp_if;
   import mnps_pkg::*;
   logic      valid;
   logic      ready;
   value_type pivot;
   modport source (output valid, pivot, input ready);
   modport sink (input valid, pivot, output ready);
endinterface

>>> rtl/core/mean_nearest_pivot_select.sv
// mean nearest pivot select, top level: loader, job queue, divider and scan back end
// loading takes one beat per cycle and waits while a queued or scanned set holds the store
// after the last beat the job passes through the queue to the one-bit-per-cycle mean
// divider (SUM_W = 32 + clog2(MAX_ITEMS+1), 42 by default) and then to the one-read-per-cycle
// scan of the N stored values; a two-value set skips both and answers straight from its
// queued job; a match with the mean ends the scan early
// synchronous reset clears counts, sums and control; the value store is not cleared
`timescale 1ns / 1ps

module mean_nearest_pivot_select #(
   parameter int MAX_ITEMS = mnps_pkg::MAX_ITEMS_DEF
) (
   input logic        clock,
   input logic        reset,
   mnps_req_if.sink   req,
   mnps_rsp_if.source rsp
);
   import mnps_pkg::*;

   localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
   localparam int ADDR_W = $clog2(MAX_ITEMS);
   localparam int SUM_W  = VALUE_W + CNT_W;
   localparam int JOB_W  = CNT_W + SUM_W + 2 * VALUE_W + 1;

   logic              push_valid, push_ready;
   logic [JOB_W-1:0]  push_data;
   logic              pop_valid, pop_ready;
   logic [JOB_W-1:0]  pop_data;
   logic [ADDR_W-1:0] rd_addr;
   value_type         rd_data;
   back_status_type   bk_status;

   mnps_front #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .job_pending (pop_valid),
      .bk_status   (bk_status),
      .job_valid   (push_valid),
      .job_data    (push_data),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

   mnps_queue #(
      .W (JOB_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   mnps_back #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job_ready (pop_ready),
      .job_data  (pop_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .bk_status (bk_status),
      .rsp       (rsp)
   );

   // no beat is written into the store while the back end reads it
   a_no_load_during_scan: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |-> !bk_status.mem_busy)
      else $error("beat accepted while the store is being scanned");

   // a closing beat always finds room in the queue
   a_job_not_lost: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.last) |-> push_ready)
      else $error("set closed with the job queue full");

   // the closing beat shows up as a queued job in the next cycle
   a_job_queued: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.last) |=> pop_valid)
      else $error("closing beat produced no job");

   // a result only follows a scan or a job taken straight from the queue
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> ($past(bk_status.mem_busy) || $past(pop_valid && pop_ready)))
      else $error("result raised without a job behind it");

endmodule

>>> rtl/core/mnps_front.sv
// loader: stores the set, keeps running count, sum, min and max, emits a job on last
// depends on mnps_pkg and mnps_req_if
`timescale 1ns / 1ps

module mnps_front #(
   parameter int MAX_ITEMS = mnps_pkg::MAX_ITEMS_DEF,
   localparam int CNT_W    = $clog2(MAX_ITEMS + 1),
   localparam int ADDR_W   = $clog2(MAX_ITEMS),
   localparam int SUM_W    = mnps_pkg::VALUE_W + CNT_W,
   localparam int JOB_W    = CNT_W + SUM_W + 2 * mnps_pkg::VALUE_W + 1
) (
   input  logic                      clock,
   input  logic                      reset,
   mnps_req_if.sink                  req,
   input  logic                      job_pending,
   input  mnps_pkg::back_status_type bk_status,
   output logic                      job_valid,
   output logic [JOB_W-1:0]          job_data,
   input  logic [ADDR_W-1:0]         rd_addr,
   output mnps_pkg::value_type       rd_data
);
   import mnps_pkg::*;

   typedef struct packed {
      logic [CNT_W-1:0]        cnt;
      logic signed [SUM_W-1:0] sum;
      value_type               vmin;
      value_type               vmax;
      logic                    side;
   } job_type;

   value_type               store_ff [MAX_ITEMS];
   value_type               rd_data_ff;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   value_type               min_ff, min_in;
   value_type               max_ff, max_in;
   logic                    accept;
   logic                    stored;
   job_type                 job;

   // memory stays with the back end until its scan is over and the job has left the queue
   assign req.ready = !job_pending && !bk_status.mem_busy;
   assign accept    = req.valid && req.ready;
   assign stored    = (count_ff != CNT_W'(MAX_ITEMS));

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      // a beat beyond capacity is dropped but its last flag still closes the set
      if (stored) begin
         count_in = count_ff + CNT_W'(1);
         sum_in   = sum_ff + {{(SUM_W - VALUE_W){req.value[VALUE_W-1]}}, req.value};
         if (count_ff == '0) begin
            min_in = req.value;
            max_in = req.value;
         end else begin
            min_in = (req.value < min_ff) ? req.value : min_ff;
            max_in = (req.value > max_ff) ? req.value : max_ff;
         end
      end
      job.cnt  = count_in;
      job.sum  = sum_in;
      job.vmin = min_in;
      job.vmax = max_in;
      job.side = req.side_a;
   end

   assign job_valid = accept && req.last;
   assign job_data  = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         min_ff   <= '0;
         max_ff   <= '0;
      end else if (accept) begin
         if (req.last) begin
            count_ff <= '0;
            sum_ff   <= '0;
            min_ff   <= '0;
            max_ff   <= '0;
         end else begin
            count_ff <= count_in;
            sum_ff   <= sum_in;
            min_ff   <= min_in;
            max_ff   <= max_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && stored) begin
         store_ff[count_ff[ADDR_W-1:0]] <= req.value;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/mnps_queue.sv
// two-entry job queue between loader and back end
// depends on nothing but its width parameter
`timescale 1ns / 1ps

module mnps_queue #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  logic [W-1:0] push_data,
   output logic         pop_valid,
   input  logic         pop_ready,
   output logic [W-1:0] pop_data
);
   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int LVL_W = $clog2(DEPTH + 1);

   logic [W-1:0]     entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic             do_push, do_pop;

   assign push_ready = (level_ff != LVL_W'(DEPTH));
   assign pop_valid  = (level_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      level_in  = level_ff;
      if (do_push && !do_pop) begin
         level_in = level_ff + LVL_W'(1);
      end else if (do_pop && !do_push) begin
         level_in = level_ff - LVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/mnps_back.sv
// back end: serial mean divider, scan of the stored set, pivot result register
// depends on mnps_pkg and mnps_rsp_if
`timescale 1ns / 1ps

module mnps_back #(
   parameter int MAX_ITEMS = mnps_pkg::MAX_ITEMS_DEF,
   localparam int CNT_W    = $clog2(MAX_ITEMS + 1),
   localparam int ADDR_W   = $clog2(MAX_ITEMS),
   localparam int SUM_W    = mnps_pkg::VALUE_W + CNT_W,
   localparam int JOB_W    = CNT_W + SUM_W + 2 * mnps_pkg::VALUE_W + 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      job_valid,
   output logic                      job_ready,
   input  logic [JOB_W-1:0]          job_data,
   output logic [ADDR_W-1:0]         rd_addr,
   input  mnps_pkg::value_type       rd_data,
   output mnps_pkg::back_status_type bk_status,
   mnps_rsp_if.source                rsp
);
   import mnps_pkg::*;

   localparam int BIT_W = $clog2(SUM_W);

   typedef struct packed {
      logic [CNT_W-1:0]        cnt;
      logic signed [SUM_W-1:0] sum;
      value_type               vmin;
      value_type               vmax;
      logic                    side;
   } job_type;

   job_type          job;
   back_state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [BIT_W-1:0] bit_ff, bit_in;
   logic             neg_ff, neg_in;
   value_type        min_ff, min_in;
   value_type        max_ff, max_in;
   value_type        mean_ff, mean_in;
   logic [CNT_W-1:0] addr_ff, addr_in;
   logic             rd_pend_ff, rd_pend_in;
   value_type        below_ff, below_in;
   value_type        above_ff, above_in;
   logic             found_ff, found_in;
   value_type        pivot_ff, pivot_in;
   logic [SUM_W-1:0] sum_mag;
   logic [CNT_W:0]   rem_sh;
   logic             ge;
   logic             issue;
   logic             between;

   assign job     = job_type'(job_data);
   assign sum_mag = job.sum[SUM_W-1] ? SUM_W'(-job.sum) : SUM_W'(job.sum);

   assign job_ready          = (state_ff == BK_IDLE);
   assign bk_status.mem_busy = (state_ff == BK_DIV) || (state_ff == BK_SCAN);
   assign rsp.valid          = (state_ff == BK_RESP);
   assign rsp.pivot          = pivot_ff;
   assign rd_addr            = addr_ff[ADDR_W-1:0];

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      bit_in     = bit_ff;
      neg_in     = neg_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      mean_in    = mean_ff;
      addr_in    = addr_ff;
      rd_pend_in = rd_pend_ff;
      below_in   = below_ff;
      above_in   = above_ff;
      found_in   = found_ff;
      pivot_in   = pivot_ff;
      // restoring division step on the magnitude of the sum, one quotient bit a cycle
      rem_sh     = {rem_ff, quo_ff[SUM_W-1]};
      ge         = (rem_sh >= {1'b0, cnt_ff});
      issue      = (addr_ff != cnt_ff);
      between    = (rd_data > min_ff) && (rd_data < max_ff);
      case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               cnt_in  = job.cnt;
               min_in  = job.vmin;
               max_in  = job.vmax;
               neg_in  = job.sum[SUM_W-1];
               quo_in  = sum_mag;
               rem_in  = '0;
               bit_in  = BIT_W'(SUM_W - 1);
               if (job.cnt == CNT_W'(2)) begin
                  pivot_in = job.side ? job.vmax : job.vmin;
                  state_in = BK_RESP;
               end else begin
                  state_in = BK_DIV;
               end
            end
         end
         BK_DIV: begin
            rem_in = CNT_W'(ge ? rem_sh - {1'b0, cnt_ff} : rem_sh);
            quo_in = {quo_ff[SUM_W-2:0], ge};
            bit_in = bit_ff - BIT_W'(1);
            if (bit_ff == '0) begin
               // quotient truncates toward zero, then takes the sign of the sum
               mean_in    = neg_ff ? value_type'(-quo_in[VALUE_W-1:0])
                                   : value_type'(quo_in[VALUE_W-1:0]);
               addr_in    = '0;
               rd_pend_in = 1'b0;
               below_in   = min_ff;
               above_in   = max_ff;
               found_in   = 1'b0;
               state_in   = BK_SCAN;
            end
         end
         BK_SCAN: begin
            if (issue) begin
               addr_in = addr_ff + CNT_W'(1);
            end
            rd_pend_in = issue;
            if (rd_pend_ff) begin
               if (between && (rd_data == mean_ff)) begin
                  pivot_in = mean_ff;
                  state_in = BK_RESP;
               end else begin
                  if (between && (rd_data < mean_ff)) begin
                     found_in = 1'b1;
                     if (rd_data > below_ff) begin
                        below_in = rd_data;
                     end
                  end else if (between && (rd_data < above_ff)) begin
                     above_in = rd_data;
                  end
                  if (!issue) begin
                     pivot_in = found_in ? below_in : above_in;
                     state_in = BK_RESP;
                  end
               end
            end
         end
         BK_RESP: begin
            if (rsp.ready) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      bit_ff     <= bit_in;
      neg_ff     <= neg_in;
      min_ff     <= min_in;
      max_ff     <= max_in;
      mean_ff    <= mean_in;
      addr_ff    <= addr_in;
      rd_pend_ff <= rd_pend_in;
      below_ff   <= below_in;
      above_ff   <= above_in;
      found_ff   <= found_in;
      pivot_ff   <= pivot_in;
   end

endmodule

>>> sim/tb_mean_nearest_pivot_select.sv
// self-checking bench for mean_nearest_pivot_select: queued request beats, pivot prediction
// depends on mnps_pkg, mnps_if.sv and the mean_nearest_pivot_select rtl
`timescale 1ns / 1ps

module tb_mean_nearest_pivot_select;
   import mnps_pkg::*;

   localparam int        SET_CAP     = MAX_ITEMS_DEF;
   localparam int        SUM_W       = VALUE_W + $clog2(SET_CAP + 1);
   localparam int        DRAIN_CYCLES = SUM_W + SET_CAP + 16;
   localparam int        RANDOM_BEATS = 1750;
   localparam value_type VAL_MIN     = 32'sh8000_0000;
   localparam value_type VAL_MAX     = 32'sh7FFF_FFFF;

   typedef struct packed {
      value_type value;
      logic      last;
      logic      side_a;
   } stim_beat_type;

   typedef enum int {
      SPREAD_FULL,
      SPREAD_TINY,
      SPREAD_EXTREME,
      SPREAD_CLUSTER,
      SPREAD_MEAN_HIT
   } spread_type;

   typedef enum int {
      PH_STEADY,
      PH_SEND_GAPS,
      PH_RECV_STALLS,
      PH_BOTH_IDLE
   } load_phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mnps_req_if req_bus ();
   mnps_rsp_if rsp_bus ();

   // bench-side drivers start known, the interface follows them
   logic          drv_valid  = 1'b0;
   stim_beat_type drv_beat   = '0;
   logic          take_ready = 1'b0;

   assign req_bus.valid  = drv_valid;
   assign req_bus.value  = drv_beat.value;
   assign req_bus.last   = drv_beat.last;
   assign req_bus.side_a = drv_beat.side_a;
   assign rsp_bus.ready  = take_ready;

   mean_nearest_pivot_select dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   stim_beat_type beat_q[$];
   value_type     pivot_q[$];
   int            taken_beats = 0;
   int            total_beats = 1;
   int            fails = 0;

   // predictor copy of the set being loaded
   value_type  loaded_vals[$];
   longint     loaded_sum = 0;
   value_type  loaded_lo = '0;
   value_type  loaded_hi = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned idle_pct(bit for_receiver);
      int ph;
      ph = taken_beats * 4 / total_beats;
      if (ph > 3) ph = 3;
      case (load_phase_type'(ph))
         PH_STEADY:      return 0;
         PH_SEND_GAPS:   return for_receiver ? 0 : 50;
         PH_RECV_STALLS: return for_receiver ? 50 : 0;
         default:        return 32;
      endcase
   endfunction

   task automatic queue_set(input value_type vals[$], input bit side);
      stim_beat_type b;
      for (int i = 0; i < vals.size(); i++) begin
         b.value  = vals[i];
         b.last   = (i == vals.size() - 1);
         b.side_a = b.last ? side : 1'($urandom_range(0, 1));
         beat_q.push_back(b);
      end
   endtask

   task automatic build_random_set(input int n);
      value_type   vals[$];
      value_type   base, tmp;
      spread_type  spread;
      int          k;
      int unsigned d;
      spread = spread_type'($urandom_range(0, 4));
      base   = value_type'($urandom);
      case (spread)
         SPREAD_FULL:
            repeat (n) vals.push_back(value_type'($urandom));
         SPREAD_TINY:
            repeat (n) vals.push_back(value_type'($urandom_range(0, 8)) - 32'sd4);
         SPREAD_EXTREME:
            repeat (n) vals.push_back($urandom_range(0, 1) ?
                                      VAL_MIN + value_type'($urandom_range(0, 3)) :
                                      VAL_MAX - value_type'($urandom_range(0, 3)));
         SPREAD_CLUSTER:
            repeat (n) vals.push_back(base + value_type'($urandom_range(0, 15)));
         default: begin
            // symmetric pairs around a center so the mean lands on a stored value
            base = base >>> 2;
            if (n % 2 == 1) vals.push_back(base);
            else if (n >= 4) begin
               vals.push_back(base);
               vals.push_back(base);
            end
            while (vals.size() < n) begin
               d = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1 << 27) :
                                               $urandom_range(1, 1000);
               vals.push_back(base - value_type'(d));
               vals.push_back(base + value_type'(d));
            end
         end
      endcase
      for (int j = 0; j < vals.size(); j++) begin
         k       = $urandom_range(0, vals.size() - 1);
         tmp     = vals[j];
         vals[j] = vals[k];
         vals[k] = tmp;
      end
      queue_set(vals, 1'($urandom_range(0, 1)));
   endtask

   always @(posedge clock) begin : drive_req
      value_type  v, pick, below, above;
      longint     mean;
      bit         hit, found_below;
      logic       next_valid;
      if (!reset) begin
         next_valid = drv_valid;
         if (drv_valid && req_bus.ready) begin
            taken_beats++;
            v = drv_beat.value;
            // a full store drops the beat but a last flag still closes the set
            if (loaded_vals.size() < SET_CAP) begin
               if (loaded_vals.size() == 0) begin
                  loaded_lo = v;
                  loaded_hi = v;
               end else begin
                  if (v < loaded_lo) loaded_lo = v;
                  if (v > loaded_hi) loaded_hi = v;
               end
               loaded_sum += longint'(v);
               loaded_vals.push_back(v);
            end
            if (drv_beat.last) begin
               mean = loaded_sum / longint'(loaded_vals.size());
               if (loaded_vals.size() == 2) begin
                  pick = drv_beat.side_a ? loaded_hi : loaded_lo;
               end else begin
                  hit         = 1'b0;
                  found_below = 1'b0;
                  below       = loaded_lo;
                  above       = loaded_hi;
                  pick        = '0;
                  foreach (loaded_vals[k]) begin
                     if (!hit && loaded_vals[k] > loaded_lo && loaded_vals[k] < loaded_hi) begin
                        if (longint'(loaded_vals[k]) == mean) begin
                           hit  = 1'b1;
                           pick = loaded_vals[k];
                        end else if (longint'(loaded_vals[k]) < mean) begin
                           if (loaded_vals[k] > below) below = loaded_vals[k];
                           found_below = 1'b1;
                        end else if (loaded_vals[k] < above) begin
                           above = loaded_vals[k];
                        end
                     end
                  end
                  if (!hit) pick = found_below ? below : above;
               end
               pivot_q.push_back(pick);
               loaded_vals.delete();
               loaded_sum = 0;
               loaded_lo  = '0;
               loaded_hi  = '0;
            end
            next_valid = 1'b0;
         end
         if (!next_valid && beat_q.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
            drv_beat   <= beat_q.pop_front();
            next_valid = 1'b1;
         end
         drv_valid <= next_valid;
      end
   end

   always @(posedge clock) begin : check_rsp
      value_type want;
      if (!reset) begin
         if (rsp_bus.valid && take_ready) begin
            if (pivot_q.size() == 0) begin
               $display("%0t ns: pivot expected none, got %0d", $time, rsp_bus.pivot);
               fails++;
            end else begin
               want = pivot_q.pop_front();
               if (rsp_bus.pivot !== want) begin
                  $display("%0t ns: pivot expected %0d, got %0d", $time, want, rsp_bus.pivot);
                  fails++;
               end
            end
         end
         take_ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
      end
   end

   initial begin : run_ctl
      value_type dset[$];
      int        target, n, r;
      bit        big_done;

      // directed sets: extremes, both two-value sides, wide sums, mean hit and misses
      dset = {VAL_MIN};                              queue_set(dset, 1'b0);
      dset = {VAL_MAX};                              queue_set(dset, 1'b1);
      dset = {VAL_MIN, VAL_MAX};                     queue_set(dset, 1'b1);
      dset = {VAL_MAX, VAL_MIN};                     queue_set(dset, 1'b0);
      dset = {VAL_MAX, VAL_MAX, VAL_MAX};            queue_set(dset, 1'b1);
      dset = {-32'sd3, 32'sd1, 32'sd5};              queue_set(dset, 1'b0);
      dset = {32'sd0, 32'sd1, 32'sd2, 32'sd100};     queue_set(dset, 1'b1);
      dset = {32'sd0, 32'sd90, 32'sd91, 32'sd100};   queue_set(dset, 1'b0);
      dset = {VAL_MIN, -32'sd1, -32'sd2, VAL_MAX};   queue_set(dset, 1'b1);

      target   = beat_q.size() + RANDOM_BEATS;
      big_done = 1'b0;
      while (beat_q.size() < target) begin
         r = $urandom_range(0, 99);
         if (!big_done && beat_q.size() > target / 2) begin
            // overfill the store so trailing beats, last among them, get dropped
            n        = SET_CAP + 1 + $urandom_range(0, 7);
            big_done = 1'b1;
         end else if (r < 15) n = 1;
         else if (r < 35) n = 2;
         else if (r < 85) n = $urandom_range(3, 12);
         else n = $urandom_range(13, 64);
         build_random_set(n);
      end
      total_beats = beat_q.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (beat_q.size() != 0 || drv_valid || pivot_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fails == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
